// ===== rtl/sbe_pkg.sv =====
`default_nettype none

package sbe_pkg;

   localparam int STACK_DEPTH   = 256;
   localparam int VALUE_WIDTH   = 64;
   localparam int OPERAND_WIDTH = 16;

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int IDX_W  = ADDR_W + 1;
   localparam int SUM_W  = (IDX_W > OPERAND_WIDTH ? IDX_W : OPERAND_WIDTH) + 1;
   localparam int OFF_W  = OPERAND_WIDTH + 1;
   localparam int TOP_W  = 64;

   typedef enum logic [3:0] {
      CMD_ENTER     = 4'd0,
      CMD_PUSHCONST = 4'd1,
      CMD_DROP      = 4'd2,
      CMD_ADD       = 4'd3,
      CMD_SUB       = 4'd4,
      CMD_JMP       = 4'd5,
      CMD_JEQ       = 4'd6,
      CMD_JNE       = 4'd7,
      CMD_JGT       = 4'd8,
      CMD_JGE       = 4'd9,
      CMD_JLT       = 4'd10,
      CMD_JLE       = 4'd11,
      CMD_PUSHVAR   = 4'd12,
      CMD_POPVAR    = 4'd13,
      CMD_RETURN    = 4'd14
   } cmd_type;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [ADDR_W-1:0]             addr_type;
   typedef logic [IDX_W-1:0]              index_type;

   typedef struct packed {
      cmd_type                         command;
      logic signed [OPERAND_WIDTH-1:0] operand;
      logic [3:0]                      arg_count;
      logic [3:0]                      temp_count;
   } req_type;

   typedef struct packed {
      logic signed [OFF_W-1:0] next_offset;
      logic                    branch_taken;
      logic signed [TOP_W-1:0] top_value;
      logic                    returned;
      logic                    fault;
   } rsp_type;

   typedef struct packed {
      cmd_type                         command;
      logic                            ok;
      logic signed [OPERAND_WIDTH-1:0] operand;
      logic                            empty;
      logic                            same_slot;
      addr_type                        wr_addr;
   } exe_type;

   typedef struct packed {
      logic     en;
      addr_type addr0;
      addr_type addr1;
   } ram_rd_type;

   typedef struct packed {
      logic      en;
      addr_type  addr;
      value_type data;
   } ram_wr_type;

endpackage

`default_nettype wire

// ===== rtl/sbe_stack_ram.sv =====
`default_nettype none

module sbe_stack_ram (
   input  wire                 clock,
   input  sbe_pkg::ram_rd_type rd,
   input  sbe_pkg::ram_wr_type wr,
   output sbe_pkg::value_type  rd0_data,
   output sbe_pkg::value_type  rd1_data
);
   import sbe_pkg::*;

   value_type mem [STACK_DEPTH];
   value_type rd0_ff;
   value_type rd1_ff;
   value_type wr_data_ff;
   logic      rd0_fwd_ff;
   logic      rd1_fwd_ff;
   logic      rd0_fwd_in;
   logic      rd1_fwd_in;

   // A write in the same cycle as a read of the same entry is passed through.
   always_comb begin
      rd0_fwd_in = wr.en && (wr.addr == rd.addr0);
      rd1_fwd_in = wr.en && (wr.addr == rd.addr1);
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd0_ff     <= mem[rd.addr0];
         rd1_ff     <= mem[rd.addr1];
         rd0_fwd_ff <= rd0_fwd_in;
         rd1_fwd_ff <= rd1_fwd_in;
         wr_data_ff <= wr.data;
      end
   end

   assign rd0_data = rd0_fwd_ff ? wr_data_ff : rd0_ff;
   assign rd1_data = rd1_fwd_ff ? wr_data_ff : rd1_ff;

endmodule

`default_nettype wire

// ===== rtl/sbe_issue.sv =====
`default_nettype none

module sbe_issue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  sbe_pkg::req_type    req_data,
   input  wire                 exe_done,
   output logic                exe_valid,
   output sbe_pkg::exe_type    exe,
   output sbe_pkg::ram_rd_type rd
);
   import sbe_pkg::*;

   index_type top_ff;
   index_type base_ff;
   logic      exe_valid_ff;
   exe_type   exe_ff;

   index_type top_in;
   index_type base_in;
   logic      exe_valid_in;
   exe_type   exe_in;
   logic      accept;
   logic      fault;
   logic      neg;

   logic [SUM_W-1:0] top_s;
   logic [SUM_W-1:0] base_s;
   logic [SUM_W-1:0] op_s;
   logic [SUM_W-1:0] var_s;
   logic [SUM_W-1:0] depth_s;
   logic [SUM_W-1:0] na_s;
   logic [SUM_W-1:0] nt_s;
   logic [SUM_W-1:0] newtop_s;
   logic [SUM_W-1:0] rd0_s;
   logic [SUM_W-1:0] rd1_s;
   logic [SUM_W-1:0] wr_s;

   assign req_ready = !exe_valid_ff || exe_done;
   assign accept    = req_valid && req_ready;

   always_comb begin
      top_s    = SUM_W'(top_ff);
      base_s   = SUM_W'(base_ff);
      op_s     = SUM_W'($unsigned(req_data.operand));
      var_s    = base_s + op_s;
      depth_s  = SUM_W'(STACK_DEPTH);
      na_s     = SUM_W'(req_data.arg_count);
      nt_s     = SUM_W'(req_data.temp_count);
      neg      = req_data.operand[OPERAND_WIDTH-1];
      fault    = 1'b0;
      newtop_s = top_s;
      base_in  = base_ff;
      rd0_s    = top_s - SUM_W'(2);
      rd1_s    = top_s - SUM_W'(3);
      wr_s     = top_s;
      unique case (req_data.command)
         CMD_ENTER: begin
            fault    = (na_s > top_s) || (top_s + nt_s > depth_s);
            newtop_s = top_s + nt_s;
            base_in  = IDX_W'(top_s - na_s);
            rd0_s    = top_s + nt_s - SUM_W'(1);
         end
         CMD_PUSHCONST: begin
            fault    = top_s >= depth_s;
            newtop_s = top_s + SUM_W'(1);
         end
         CMD_DROP: begin
            fault    = top_s < SUM_W'(1);
            newtop_s = top_s - SUM_W'(1);
         end
         CMD_ADD, CMD_SUB: begin
            fault    = top_s < SUM_W'(2);
            newtop_s = top_s - SUM_W'(1);
            wr_s     = top_s - SUM_W'(2);
         end
         CMD_JEQ, CMD_JNE, CMD_JGT, CMD_JGE, CMD_JLT, CMD_JLE: begin
            fault    = top_s < SUM_W'(2);
            newtop_s = top_s - SUM_W'(2);
         end
         CMD_PUSHVAR: begin
            fault    = neg || (base_s >= top_s) || (var_s >= top_s) || (top_s >= depth_s);
            newtop_s = top_s + SUM_W'(1);
            rd0_s    = var_s;
         end
         CMD_POPVAR: begin
            fault    = (top_s < SUM_W'(1)) || neg || (base_s >= top_s - SUM_W'(1))
                       || (var_s >= top_s - SUM_W'(1));
            newtop_s = top_s - SUM_W'(1);
            wr_s     = var_s;
         end
         CMD_RETURN: begin
            fault    = (top_s == '0) || (base_s > top_s);
            newtop_s = base_s;
            rd0_s    = base_s - SUM_W'(1);
         end
         default: begin
         end
      endcase
      if (fault) begin
         newtop_s = top_s;
         base_in  = base_ff;
      end
      top_in            = IDX_W'(newtop_s);
      exe_in.command    = req_data.command;
      exe_in.ok         = !fault;
      exe_in.operand    = req_data.operand;
      exe_in.empty      = newtop_s == '0;
      exe_in.same_slot  = var_s == top_s - SUM_W'(2);
      exe_in.wr_addr    = ADDR_W'(wr_s);
      exe_valid_in      = accept ? 1'b1 : (exe_done ? 1'b0 : exe_valid_ff);
   end

   assign rd.en    = accept;
   assign rd.addr0 = ADDR_W'(rd0_s);
   assign rd.addr1 = ADDR_W'(rd1_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         base_ff      <= '0;
         exe_valid_ff <= 1'b0;
      end else begin
         exe_valid_ff <= exe_valid_in;
         if (accept) begin
            top_ff  <= top_in;
            base_ff <= base_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         exe_ff <= exe_in;
      end
   end

   assign exe_valid = exe_valid_ff;
   assign exe       = exe_ff;

endmodule

`default_nettype wire

// ===== rtl/sbe_execute.sv =====
`default_nettype none

module sbe_execute (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 exe_valid,
   input  sbe_pkg::exe_type    exe,
   output logic                exe_done,
   input  sbe_pkg::value_type  rd0_data,
   input  sbe_pkg::value_type  rd1_data,
   output sbe_pkg::ram_wr_type wr,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output sbe_pkg::rsp_type    rsp_data
);
   import sbe_pkg::*;

   value_type tos_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff;

   value_type tos_in;
   logic      rsp_valid_in;
   rsp_type   rsp_in;
   value_type left_v;
   value_type right_v;
   value_type wr_data;
   logic      wr_en;
   logic      taken;
   logic      ret;

   always_comb begin
      left_v  = rd0_data;
      right_v = tos_ff;
      tos_in  = tos_ff;
      wr_en   = 1'b0;
      wr_data = tos_ff;
      taken   = 1'b0;
      ret     = 1'b0;
      if (exe.ok) begin
         unique case (exe.command)
            CMD_ENTER, CMD_DROP: begin
               tos_in = rd0_data;
            end
            CMD_PUSHCONST: begin
               wr_en   = 1'b1;
               wr_data = VALUE_WIDTH'(exe.operand);
               tos_in  = wr_data;
            end
            CMD_ADD: begin
               wr_en   = 1'b1;
               wr_data = left_v + right_v;
               tos_in  = wr_data;
            end
            CMD_SUB: begin
               wr_en   = 1'b1;
               wr_data = left_v - right_v;
               tos_in  = wr_data;
            end
            CMD_JMP: begin
               taken = 1'b1;
            end
            CMD_JEQ: begin
               taken  = left_v == right_v;
               tos_in = rd1_data;
            end
            CMD_JNE: begin
               taken  = left_v != right_v;
               tos_in = rd1_data;
            end
            CMD_JGT: begin
               taken  = left_v > right_v;
               tos_in = rd1_data;
            end
            CMD_JGE: begin
               taken  = left_v >= right_v;
               tos_in = rd1_data;
            end
            CMD_JLT: begin
               taken  = left_v < right_v;
               tos_in = rd1_data;
            end
            CMD_JLE: begin
               taken  = left_v <= right_v;
               tos_in = rd1_data;
            end
            CMD_PUSHVAR: begin
               wr_en   = 1'b1;
               wr_data = rd0_data;
               tos_in  = rd0_data;
            end
            CMD_POPVAR: begin
               wr_en   = 1'b1;
               wr_data = tos_ff;
               tos_in  = exe.same_slot ? tos_ff : rd0_data;
            end
            CMD_RETURN: begin
               ret    = 1'b1;
               tos_in = rd0_data;
            end
            default: begin
            end
         endcase
      end
      rsp_in.next_offset  = taken ? OFF_W'(exe.operand) + OFF_W'(1) : OFF_W'(1);
      rsp_in.branch_taken = taken;
      rsp_in.returned     = ret;
      rsp_in.fault        = !exe.ok;
      if (ret) begin
         rsp_in.top_value = TOP_W'(tos_ff);
      end else if (exe.empty) begin
         rsp_in.top_value = '0;
      end else begin
         rsp_in.top_value = TOP_W'(tos_in);
      end
      exe_done     = exe_valid && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in = exe_done ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign wr.en   = exe_done && wr_en;
   assign wr.addr = exe.wr_addr;
   assign wr.data = wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exe_done) begin
         tos_ff <= tos_in;
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/stack_bytecode_executor_core.sv =====
// Stack-machine instruction executor. Each request transaction carries one decoded
// instruction and yields one response transaction. An instruction is accepted in
// every cycle while the response register is free or being taken, so the block
// sustains one instruction per cycle; a request passes the execute stage register, then
// the response register. Stack indices and faults are settled at acceptance, where both
// operand reads are issued to the two read ports of the stack memory; the execute stage
// then computes the result, writes the memory and updates the cached top entry. The stack
// memory holds undefined contents after reset and needs no clearing.
`default_nettype none

module stack_bytecode_executor_core (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  sbe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output sbe_pkg::rsp_type rsp_data
);
   import sbe_pkg::*;

   logic       exe_valid;
   logic       exe_done;
   exe_type    exe;
   ram_rd_type rd;
   ram_wr_type wr;
   value_type  rd0_data;
   value_type  rd1_data;

   sbe_issue u_issue (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .exe_done  (exe_done),
      .exe_valid (exe_valid),
      .exe       (exe),
      .rd        (rd)
   );

   sbe_stack_ram u_ram (
      .clock    (clock),
      .rd       (rd),
      .wr       (wr),
      .rd0_data (rd0_data),
      .rd1_data (rd1_data)
   );

   sbe_execute u_execute (
      .clock     (clock),
      .reset     (reset),
      .exe_valid (exe_valid),
      .exe       (exe),
      .exe_done  (exe_done),
      .rd0_data  (rd0_data),
      .rd1_data  (rd1_data),
      .wr        (wr),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
